### sv/websocket_frame_deframer_top_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define WSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/wsd_pkg.sv
// Types and constants of the WebSocket frame deframer.
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEN     = 3'd1,
		PH_EXT_HI  = 3'd2,
		PH_EXT_LO  = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_LEN64 = 2'd2,
		KIND_ABORT = 2'd3
	} kind_t;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [1:0] MASK_LAST_POS = 2'd3;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [6:0] opcode;
		logic       last;
	} wsd_result_t;

endpackage

### sv/wsd_parser.sv
// Frame header state machine, unmasking and result formation for one byte per cycle in which step is high.
module wsd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic                 link_down,
	output logic                 res_valid,
	output wsd_pkg::wsd_result_t res
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [6:0]  held_opcode_q;
	logic        masked_q;
	logic [15:0] remaining_q;
	logic [7:0]  mask_key_q [4];
	logic [1:0]  byte_pos_q;

	logic [6:0]  len7;
	logic [15:0] ext_len;
	logic [15:0] rem_dec;

	assign len7    = rx_byte[6:0];
	assign ext_len = {remaining_q[15:8], rx_byte};
	assign rem_dec = remaining_q - 16'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (link_down) begin
				phase_d = PH_IDLE;
			end else begin
				case (phase_q)
					PH_IDLE: phase_d = PH_LEN;
					PH_LEN: begin
						if (len7 == LEN_EXT16) phase_d = PH_EXT_HI;
						else if (len7 == LEN_EXT64) phase_d = PH_IDLE;
						else if (rx_byte[7]) phase_d = PH_MASK;
						else if (len7 == 7'd0) phase_d = PH_IDLE;
						else phase_d = PH_PAYLOAD;
					end
					PH_EXT_HI: phase_d = PH_EXT_LO;
					PH_EXT_LO: begin
						if (masked_q) phase_d = PH_MASK;
						else if (ext_len == 16'd0) phase_d = PH_IDLE;
						else phase_d = PH_PAYLOAD;
					end
					PH_MASK: begin
						if (byte_pos_q == MASK_LAST_POS)
							phase_d = (remaining_q == 16'd0) ? PH_IDLE : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (rem_dec == 16'd0) phase_d = PH_IDLE;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// result
	always_comb begin
		res_valid  = 1'b0;
		res.kind   = KIND_EMPTY;
		res.data   = 8'd0;
		res.opcode = held_opcode_q;
		res.last   = 1'b1;
		if (step) begin
			if (link_down) begin
				if (phase_q != PH_IDLE) begin
					res_valid = 1'b1;
					res.kind  = KIND_ABORT;
				end
			end else begin
				case (phase_q)
					PH_LEN: begin
						if (len7 == LEN_EXT64) begin
							res_valid = 1'b1;
							res.kind  = KIND_LEN64;
						end else if (len7 == 7'd0 && !rx_byte[7]) begin
							res_valid = 1'b1;
						end
					end
					PH_EXT_LO: begin
						if (!masked_q && ext_len == 16'd0) res_valid = 1'b1;
					end
					PH_MASK: begin
						if (byte_pos_q == MASK_LAST_POS && remaining_q == 16'd0)
							res_valid = 1'b1;
					end
					PH_PAYLOAD: begin
						res_valid = 1'b1;
						res.kind  = KIND_DATA;
						res.data  = masked_q ? (rx_byte ^ mask_key_q[byte_pos_q]) : rx_byte;
						res.last  = (rem_dec == 16'd0);
					end
					default: res_valid = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_opcode_q <= 7'd0;
			masked_q      <= 1'b0;
			remaining_q   <= 16'd0;
			byte_pos_q    <= 2'd0;
			for (int i = 0; i < 4; i++) mask_key_q[i] <= 8'd0;
		end else if (step && !link_down) begin
			case (phase_q)
				PH_IDLE: begin
					held_opcode_q <= rx_byte[6:0];
					byte_pos_q    <= 2'd0;
				end
				PH_LEN: begin
					masked_q <= rx_byte[7];
					if (len7 != LEN_EXT16 && len7 != LEN_EXT64) begin
						remaining_q <= {9'd0, len7};
						byte_pos_q  <= 2'd0;
					end
				end
				PH_EXT_HI: remaining_q <= {rx_byte, 8'h00};
				PH_EXT_LO: begin
					remaining_q <= ext_len;
					byte_pos_q  <= 2'd0;
				end
				PH_MASK: begin
					mask_key_q[byte_pos_q] <= rx_byte;
					byte_pos_q             <= byte_pos_q + 2'd1;
				end
				PH_PAYLOAD: begin
					byte_pos_q  <= byte_pos_q + 2'd1;
					remaining_q <= rem_dec;
				end
				default: byte_pos_q <= byte_pos_q;
			endcase
		end
	end

endmodule

### sv/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer: parser plus two-deep result buffer.
// One received byte is taken per cycle while in_ready is high; its result, if any, sits in
// the output register from the cycle after the request is accepted, or in the skid entry when
// an earlier result is still waiting there. The parser handles each byte combinationally, so
// the rate is set by the output side alone: a result register backed by one skid entry lets
// bytes keep coming while a result waits, and in_ready drops only once both hold undelivered
// results. Header and mask bytes give no result, save the byte that ends an empty frame or
// holds a 64-bit length; link loss while idle gives none; every payload byte gives one.
module websocket_frame_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       link_down,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [6:0] frame_opcode,
	output logic       last_of_frame
);
	import wsd_pkg::*;

	logic        step;
	logic        res_valid;
	wsd_result_t res;

	logic        out_valid_q;
	wsd_result_t out_q;
	logic        skid_valid_q;
	wsd_result_t skid_q;
	logic        take;

	assign in_ready = !skid_valid_q;
	assign step     = in_valid && in_ready;
	assign take     = out_valid_q && out_ready;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx_byte),
		.link_down (link_down),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// no new request while the skid entry is full
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) out_q <= skid_q;
		end else if (res_valid) begin
			if (out_valid_q && !take) skid_q <= res;
			else out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign data_byte     = out_q.data;
	assign frame_opcode  = out_q.opcode;
	assign last_of_frame = out_q.last;

endmodule

### sv/wsd_checker.sv
// Port-level checks of the deframer, bound to the top level.
`include "websocket_frame_deframer_top_defines.svh"

module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] rx_byte,
	input logic       link_down,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic [6:0] frame_opcode,
	input logic       last_of_frame
);
	import wsd_pkg::*;

	`WSD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte) && $stable(frame_opcode) && $stable(last_of_frame), "stalled result changed")
	`WSD_ASSERT(a_ctrl_result, out_valid && kind != KIND_DATA |-> last_of_frame && data_byte == 8'd0, "non-data result without last or with data")
	`WSD_ASSERT(a_ready_full, !in_ready |-> out_valid, "ready low with no result waiting")
	`WSD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid && in_ready, "result or stall during reset")

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the WebSocket frame deframer.
`timescale 1ns / 100ps

module tb_top;
	import wsd_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       link_down = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [6:0] frame_opcode;
	logic       last_of_frame;

	websocket_frame_deframer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.link_down     (link_down),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.data_byte     (data_byte),
		.frame_opcode  (frame_opcode),
		.last_of_frame (last_of_frame)
	);

	localparam int RANDOM_REQUESTS = 1600;
	localparam int DRAIN_CYCLES    = 20;

	// parser state mirror
	phase_t      st_phase = PH_IDLE;
	logic [6:0]  st_opcode = 7'd0;
	logic        st_masked = 1'b0;
	logic [15:0] st_remaining = 16'd0;
	logic [7:0]  st_key [4] = '{default: 8'h00};
	logic [1:0]  st_pos = 2'd0;

	wsd_result_t pending_results [$];
	wsd_result_t want;
	int          mismatches = 0;
	int          sent_count = 0;
	int          frames_sent = 0;
	int          kind_seen [4] = '{default: 0};
	bit          steady_flow = 1'b0;

	typedef struct {
		logic [7:0]  rx;
		logic        ld;
		bit          typed;
		bit          has;
		wsd_result_t res;
	} dir_row_t;

	dir_row_t dir_rows [$];

	initial begin
		forever #1 clk = ~clk;
	end

	// Next state and result for one accepted request.
	function automatic bit deframe_byte(input logic [7:0] b, input logic ld,
			output wsd_result_t r);
		bit hit;
		bit len_known;
		hit = 1'b0;
		len_known = 1'b0;
		r.kind = KIND_DATA;
		r.data = 8'h00;
		r.last = 1'b1;
		if (ld) begin
			if (st_phase != PH_IDLE) begin
				st_phase = PH_IDLE;
				r.kind = KIND_ABORT;
				hit = 1'b1;
			end
		end else begin
			case (st_phase)
			PH_IDLE: begin
				st_opcode = b[6:0];
				st_pos = 2'd0;
				st_phase = PH_LEN;
			end
			PH_LEN: begin
				st_masked = b[7];
				if (b[6:0] == LEN_EXT16) begin
					st_phase = PH_EXT_HI;
				end else if (b[6:0] == LEN_EXT64) begin
					st_phase = PH_IDLE;
					r.kind = KIND_LEN64;
					hit = 1'b1;
				end else begin
					st_remaining = {9'd0, b[6:0]};
					len_known = 1'b1;
				end
			end
			PH_EXT_HI: begin
				st_remaining = {b, 8'h00};
				st_phase = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				st_remaining = st_remaining | {8'h00, b};
				len_known = 1'b1;
			end
			PH_MASK: begin
				st_key[st_pos] = b;
				st_pos = st_pos + 2'd1;
				if (st_pos == 2'd0) begin
					if (st_remaining == 16'd0) begin
						st_phase = PH_IDLE;
						r.kind = KIND_EMPTY;
						hit = 1'b1;
					end else begin
						st_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.data = st_masked ? (b ^ st_key[st_pos]) : b;
				st_pos = st_pos + 2'd1;
				st_remaining = st_remaining - 16'd1;
				r.last = (st_remaining == 16'd0);
				if (r.last)
					st_phase = PH_IDLE;
				hit = 1'b1;
			end
			default: st_phase = PH_IDLE;
			endcase
		end
		if (len_known) begin
			st_pos = 2'd0;
			if (st_masked) begin
				st_phase = PH_MASK;
			end else if (st_remaining == 16'd0) begin
				st_phase = PH_IDLE;
				r.kind = KIND_EMPTY;
				hit = 1'b1;
			end else begin
				st_phase = PH_PAYLOAD;
			end
		end
		r.opcode = st_opcode;
		return hit;
	endfunction

	function automatic void add_row(input logic [7:0] rx, input logic ld);
		dir_row_t row;
		row.rx = rx;
		row.ld = ld;
		row.typed = 1'b0;
		row.has = 1'b0;
		row.res = '0;
		dir_rows.push_back(row);
	endfunction

	// Row with the outcome written out: nothing, or a control result that ends a frame.
	function automatic void add_typed(input logic [7:0] rx, input logic ld, input bit has,
			input kind_t k, input logic [6:0] op);
		dir_row_t row;
		row.rx = rx;
		row.ld = ld;
		row.typed = 1'b1;
		row.has = has;
		row.res.kind = k;
		row.res.data = 8'h00;
		row.res.opcode = op;
		row.res.last = 1'b1;
		dir_rows.push_back(row);
	endfunction

	task automatic send_request(input logic [7:0] b, input logic ld, input bit typed,
			input bit typed_has, input wsd_result_t typed_res);
		wsd_result_t r;
		bit hit;
		if (!steady_flow) begin
			while ($urandom_range(99) < 28) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		link_down <= ld;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		hit = deframe_byte(b, ld, r);
		if (typed) begin
			hit = typed_has;
			r = typed_res;
		end
		if (hit)
			pending_results.push_back(r);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_plain(input logic [7:0] b, input logic ld);
		send_request(b, ld, 1'b0, 1'b0, '0);
	endtask

	// Mostly well-formed frames with random content; some noise, 64-bit lengths, aborts.
	task automatic send_random_frame();
		logic [7:0]  frame_bytes [$];
		bit          msk;
		int unsigned len;
		int unsigned sel;
		int unsigned abort_at;
		sel = $urandom_range(99);
		msk = $urandom_range(1);
		if (sel < 5) begin
			send_plain(8'($urandom), 1'b1);
		end else if (sel < 9) begin
			send_plain(8'($urandom), 1'b0);
		end else if (sel < 15) begin
			send_plain(8'($urandom), 1'b0);
			send_plain({msk, LEN_EXT64}, 1'b0);
		end else begin
			frames_sent++;
			frame_bytes.push_back(8'($urandom));
			sel = $urandom_range(99);
			if (sel < 88) begin
				if (sel < 38)
					len = $urandom_range(3);
				else if (sel < 78)
					len = $urandom_range(20, 4);
				else
					len = $urandom_range(125);
				frame_bytes.push_back({msk, 7'(len)});
			end else begin
				// extended length, small values included
				len = $urandom_range(200);
				frame_bytes.push_back({msk, LEN_EXT16});
				frame_bytes.push_back(8'(len >> 8));
				frame_bytes.push_back(8'(len));
			end
			if (msk)
				repeat (4) frame_bytes.push_back(8'($urandom));
			repeat (len) frame_bytes.push_back(8'($urandom));
			abort_at = ($urandom_range(99) < 10) ?
				$urandom_range(frame_bytes.size() - 1) : frame_bytes.size();
			for (int i = 0; i < frame_bytes.size(); i++) begin
				if (i == abort_at) begin
					send_plain(8'($urandom), 1'b1);
					break;
				end
				send_plain(frame_bytes[i], 1'b0);
			end
		end
	endtask

	always @(negedge clk)
		out_ready <= steady_flow || ($urandom_range(99) >= 28);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			kind_seen[kind]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: kind %0d data %02h op %02h last %0d",
						$realtime, kind, data_byte, frame_opcode, last_of_frame);
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind || data_byte !== want.data ||
						frame_opcode !== want.opcode || last_of_frame !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: exp kind %0d data %02h op %02h last %0d,",
							$realtime, want.kind, want.data, want.opcode, want.last,
							" got kind %0d data %02h op %02h last %0d",
							kind, data_byte, frame_opcode, last_of_frame);
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		// link loss while idle, 64-bit length, empty frames, masked payload, abort
		add_typed(8'hFF, 1'b1, 1'b0, KIND_DATA, 7'h00);
		add_row(8'hFF, 1'b0);
		add_typed(8'h7F, 1'b0, 1'b1, KIND_LEN64, 7'h7F);
		add_row(8'h00, 1'b0);
		add_typed(8'h00, 1'b0, 1'b1, KIND_EMPTY, 7'h00);
		add_row(8'h81, 1'b0);
		add_row(8'h82, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'hA5, 1'b0);
		add_row(8'h5A, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(8'h89, 1'b0);
		add_row(8'hFE, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h11, 1'b0);
		add_row(8'h22, 1'b0);
		add_row(8'h33, 1'b0);
		add_typed(8'h44, 1'b0, 1'b1, KIND_EMPTY, 7'h09);
		add_row(8'h0A, 1'b0);
		add_row(8'h7E, 1'b0);
		add_row(8'hFF, 1'b0);
		add_typed(8'h00, 1'b1, 1'b1, KIND_ABORT, 7'h0A);

		// falling edge on reset at time zero so the asynchronous reset takes effect
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].rx, dir_rows[i].ld, dir_rows[i].typed,
				dir_rows[i].has, dir_rows[i].res);

		while (sent_count < dir_rows.size() + RANDOM_REQUESTS) begin
			steady_flow = (sent_count >= 700 && sent_count < 1000);
			send_random_frame();
		end
		steady_flow = 1'b0;
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d directed), %0d random frames started",
			sent_count, dir_rows.size(), frames_sent);
		$display("results: %0d payload bytes, %0d empty frames, %0d 64-bit rejects, %0d aborts",
			kind_seen[KIND_DATA], kind_seen[KIND_EMPTY], kind_seen[KIND_LEN64],
			kind_seen[KIND_ABORT]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				pending_results.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/websocket_frame_deframer_top.sv
sv/wsd_checker.sv
verif/tb_top.sv
